[hw/rtl/lbfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lbfa_pkg;

	localparam int X_W      = 13;
	localparam int ROW_W    = 10;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PLACE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
	localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_WR,
		S_PL_HEAD,
		S_PL_GAP,
		S_PL_FILE,
		S_WALK_RD,
		S_WALK_CHK,
		S_CLEAR
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/largest_blank_first_allocator.sv]
// load writes the blank on top of its bucket; func 3 or an item refused on arrival is
// answered from idle; place takes the head blank of the top bucket, misses if it is empty;
// a zero-width filler keeps the blank as is, else the rest is filed; emptying the top
// bucket walks down to a non-empty bucket or width zero; clear: one bucket head written
// per cycle; one item at a time; reset: async, active low; afterwards busy stays high
// while every bucket head is swept to empty; the receiver cannot stall, done pulses one cycle
`timescale 1ns / 1ps
`default_nettype none

module largest_blank_first_allocator
	import lbfa_pkg::*;
#(
	parameter int MAX_BLANKS = 1024,
	parameter int ROW_SITES  = 4096,
	parameter int NUM_ROWS   = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [X_W-1:0]      blank_x,
	input  wire logic [ROW_W-1:0]    blank_row,
	input  wire logic [X_W-1:0]      width_sites,
	output logic                     done,
	output logic      [X_W-1:0]      place_x,
	output logic      [ROW_W-1:0]    place_row,
	output logic      [STATUS_W-1:0] status
);

	localparam int IW  = $clog2(MAX_BLANKS + 1);
	localparam int GIW = $clog2(MAX_BLANKS);
	localparam int WW  = $clog2(ROW_SITES + 1);
	localparam int GW  = X_W + ROW_W + IW;
	localparam logic [IW-1:0] NO_ENTRY = IW'(MAX_BLANKS);

	state_t state_q, state_d;
	logic [X_W-1:0]   start_q, start_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [WW-1:0]    wb_q, wb_d;
	logic [GIW-1:0]   head_q, head_d;
	logic [IW-1:0]    link_q, link_d;
	logic [WW-1:0]    left_q, left_d;
	logic [WW-1:0]    tw_q, tw_d;
	logic [IW-1:0]    used_q, used_d;
	logic [WW-1:0]    cnt_q, cnt_d;
	logic             reply_q, reply_d;

	logic                fin;
	logic [STATUS_W-1:0] fin_status;
	logic [X_W-1:0]      fin_x;
	logic [ROW_W-1:0]    fin_row;

	logic                done_q;
	logic [X_W-1:0]      place_x_q;
	logic [ROW_W-1:0]    place_row_q;
	logic [STATUS_W-1:0] status_q;

	logic          bk_we, bk_re;
	logic [WW-1:0] bk_waddr, bk_raddr;
	logic [IW-1:0] bk_wdata, bk_rdata;

	logic           gp_we, gp_re;
	logic [GIW-1:0] gp_waddr, gp_raddr;
	logic [GW-1:0]  gp_wdata, gp_rdata;

	logic [X_W-1:0]   g_start;
	logic [ROW_W-1:0] g_row;
	logic [IW-1:0]    g_link;

	logic [WW-1:0]    w_sat;
	logic [ROW_W-1:0] row_sat;
	logic             w_over;
	logic             full;

	assign g_start = gp_rdata[GW-1 -: X_W];
	assign g_row   = gp_rdata[IW +: ROW_W];
	assign g_link  = gp_rdata[IW-1:0];

	assign w_sat   = (32'(width_sites) > ROW_SITES) ? WW'(ROW_SITES) : WW'(width_sites);
	assign row_sat = (32'(blank_row) > NUM_ROWS - 1) ? ROW_W'(NUM_ROWS - 1) : blank_row;
	assign w_over  = 32'(width_sites) > 32'(tw_q);
	assign full    = 32'(used_q) >= MAX_BLANKS;

	// bucket heads, one per remaining width
	lbfa_ram #(.WIDTH(IW), .DEPTH(ROW_SITES + 1)) u_bucket (
		.clk   (clk),
		.we    (bk_we),
		.waddr (bk_waddr),
		.wdata (bk_wdata),
		.re    (bk_re),
		.raddr (bk_raddr),
		.rdata (bk_rdata)
	);

	// blank table: start, row, link to next blank of the same bucket
	lbfa_ram #(.WIDTH(GW), .DEPTH(MAX_BLANKS)) u_gap (
		.clk   (clk),
		.we    (gp_we),
		.waddr (gp_waddr),
		.wdata (gp_wdata),
		.re    (gp_re),
		.raddr (gp_raddr),
		.rdata (gp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			tw_q    <= '0;
			used_q  <= '0;
			cnt_q   <= '0;
			reply_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tw_q    <= tw_d;
			used_q  <= used_d;
			cnt_q   <= cnt_d;
			reply_q <= reply_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		row_q   <= row_d;
		wb_q    <= wb_d;
		head_q  <= head_d;
		link_q  <= link_d;
		left_q  <= left_d;
		if (fin) begin
			place_x_q   <= fin_x;
			place_row_q <= fin_row;
			status_q    <= fin_status;
		end
	end

	always_comb begin
		state_d = state_q;
		start_d = start_q;
		row_d   = row_q;
		wb_d    = wb_q;
		head_d  = head_q;
		link_d  = link_q;
		left_d  = left_q;
		tw_d    = tw_q;
		used_d  = used_q;
		cnt_d   = cnt_q;
		reply_d = reply_q;

		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_x      = '0;
		fin_row    = '0;

		bk_re    = 1'b0;
		bk_raddr = tw_q;
		bk_we    = 1'b0;
		bk_waddr = tw_q;
		bk_wdata = NO_ENTRY;

		gp_re    = 1'b0;
		gp_raddr = head_q;
		gp_we    = 1'b0;
		gp_waddr = head_q;
		gp_wdata = {start_q, row_q, bk_rdata};

		case (state_q)
			S_IDLE: begin
				if (start) begin
					start_d = blank_x;
					row_d   = row_sat;
					case (func)
						FN_LOAD: begin
							if (full) begin
								fin        = 1'b1;
								fin_status = STAT_FULL;
							end else begin
								wb_d     = w_sat;
								bk_re    = 1'b1;
								bk_raddr = w_sat;
								state_d  = S_LD_WR;
							end
						end
						FN_PLACE: begin
							if (w_over) begin
								fin        = 1'b1;
								fin_status = STAT_MISS;
							end else begin
								wb_d     = WW'(width_sites);
								bk_re    = 1'b1;
								bk_raddr = tw_q;
								state_d  = S_PL_HEAD;
							end
						end
						FN_CLEAR: begin
							cnt_d   = '0;
							reply_d = 1'b1;
							state_d = S_CLEAR;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_LD_WR: begin
				// new blank goes on top of its bucket
				gp_we    = 1'b1;
				gp_waddr = used_q[GIW-1:0];
				gp_wdata = {start_q, row_q, bk_rdata};
				bk_we    = 1'b1;
				bk_waddr = wb_q;
				bk_wdata = used_q;
				if (wb_q > tw_q) begin
					tw_d = wb_q;
				end
				used_d  = used_q + IW'(1);
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_PL_HEAD: begin
				if (32'(bk_rdata) >= MAX_BLANKS) begin
					fin        = 1'b1;
					fin_status = STAT_MISS;
					state_d    = S_IDLE;
				end else begin
					head_d   = bk_rdata[GIW-1:0];
					gp_re    = 1'b1;
					gp_raddr = bk_rdata[GIW-1:0];
					state_d  = S_PL_GAP;
				end
			end
			S_PL_GAP: begin
				start_d = g_start;
				row_d   = g_row;
				if (wb_q == '0) begin
					// zero-width filler leaves the blank where it is
					fin     = 1'b1;
					fin_x   = g_start;
					fin_row = g_row;
					state_d = S_IDLE;
				end else begin
					link_d   = g_link;
					bk_we    = 1'b1;
					bk_waddr = tw_q;
					bk_wdata = g_link;
					left_d   = tw_q - wb_q;
					bk_re    = 1'b1;
					bk_raddr = tw_q - wb_q;
					state_d  = S_PL_FILE;
				end
			end
			S_PL_FILE: begin
				// remaining width is below the top width, so no clash with the pop
				gp_we    = 1'b1;
				gp_waddr = head_q;
				gp_wdata = {start_q + X_W'(wb_q), row_q, bk_rdata};
				bk_we    = 1'b1;
				bk_waddr = left_q;
				bk_wdata = IW'(head_q);
				if (32'(link_q) < MAX_BLANKS) begin
					fin     = 1'b1;
					fin_x   = start_q;
					fin_row = row_q;
					state_d = S_IDLE;
				end else begin
					tw_d    = tw_q - WW'(1);
					state_d = S_WALK_RD;
				end
			end
			S_WALK_RD: begin
				if (tw_q == '0) begin
					fin     = 1'b1;
					fin_x   = start_q;
					fin_row = row_q;
					state_d = S_IDLE;
				end else begin
					bk_re    = 1'b1;
					bk_raddr = tw_q;
					state_d  = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				if (32'(bk_rdata) < MAX_BLANKS) begin
					fin     = 1'b1;
					fin_x   = start_q;
					fin_row = row_q;
					state_d = S_IDLE;
				end else if (tw_q == WW'(1)) begin
					tw_d    = '0;
					fin     = 1'b1;
					fin_x   = start_q;
					fin_row = row_q;
					state_d = S_IDLE;
				end else begin
					tw_d     = tw_q - WW'(1);
					bk_re    = 1'b1;
					bk_raddr = tw_q - WW'(1);
				end
			end
			S_CLEAR: begin
				bk_we    = 1'b1;
				bk_waddr = cnt_q;
				bk_wdata = NO_ENTRY;
				if (32'(cnt_q) == ROW_SITES) begin
					tw_d    = '0;
					used_d  = '0;
					reply_d = 1'b0;
					fin     = reply_q;
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + WW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign place_x   = place_x_q;
	assign place_row = place_row_q;
	assign status    = status_q;

endmodule

`default_nettype wire

[hw/rtl/lbfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lbfa_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lbfa_checker
	import lbfa_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic [FUNC_W-1:0]   func,
	input wire logic                done,
	input wire logic [X_W-1:0]      place_x,
	input wire logic [ROW_W-1:0]    place_row,
	input wire logic [STATUS_W-1:0] status
);

	// a result always lands with the block back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a result follows an accepted item or a busy stretch
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without an item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || status == STAT_MISS || status == STAT_FULL))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STAT_OK) |-> (place_x == '0 && place_row == '0))
		else $error("failed item carries a position");

	// an accepted clear always starts the bucket sweep
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_CLEAR) |=> busy)
		else $error("clear item did not start the sweep");

endmodule

bind largest_blank_first_allocator lbfa_checker u_lbfa_checker (.*);

`default_nettype wire
